/* hdl/clars_pkg.sv */
// Shared types, codes and constants of the checksummed line sender.
// No dependencies; the other files that use it refer to it by scoped names.
`default_nettype none

package clars_pkg;

  localparam int OP_W     = 2;
  localparam int BYTE_W   = 8;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 16;
  localparam int RETRY_W  = 8;
  localparam int TICK_W   = 16;
  localparam int PHASE_W  = 2;
  localparam int TRAIL_W  = 3;
  localparam int ACKCNT_W = 3;

  localparam logic [OP_W-1:0] OP_LOAD = 2'd0;
  localparam logic [OP_W-1:0] OP_RX   = 2'd1;
  localparam logic [OP_W-1:0] OP_TICK = 2'd2;
  localparam logic [OP_W-1:0] OP_SLOT = 2'd3;

  localparam logic [PHASE_W-1:0] PH_IDLE = 2'd0;
  localparam logic [PHASE_W-1:0] PH_SEND = 2'd1;
  localparam logic [PHASE_W-1:0] PH_WAIT = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_RETRY_LIMIT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACK_TIMEOUT = 1'd1;

  localparam logic [RETRY_W-1:0] RETRY_LIMIT_RST = 8'd3;
  localparam logic [TICK_W-1:0]  ACK_TIMEOUT_RST = 16'd2000;
  localparam logic [TICK_W-1:0]  TICK_MAX        = 16'hFFFF;

  localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CH_STAR  = 8'h2A;
  localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;
  localparam logic [BYTE_W-1:0] CH_A     = 8'h41;
  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;

  localparam logic [ACKCNT_W-1:0] ACK_LEN = 3'd4;

  typedef struct packed {
    logic              tx_valid;
    logic [BYTE_W-1:0] tx_byte;
    logic              done_res;
    logic              acked;
  } out_item_t;

  typedef struct packed {
    logic [1:0] hund;
    logic [3:0] tens;
    logic [3:0] ones;
  } digits_t;

  function automatic digits_t to_digits(logic [BYTE_W-1:0] v);
    digits_t d;
    logic [BYTE_W-1:0] r;
    logic [BYTE_W-1:0] ten_part;
    d = '0;
    r = v;
    if (v >= 8'd200) begin
      d.hund = 2'd2;
      r = v - 8'd200;
    end else if (v >= 8'd100) begin
      d.hund = 2'd1;
      r = v - 8'd100;
    end
    for (int k = 1; k <= 9; k++) begin
      if (r >= 8'(k * 10)) d.tens = 4'(k);
    end
    ten_part = {1'b0, d.tens, 3'b000} + {3'b000, d.tens, 1'b0};
    d.ones = 4'(r - ten_part);
    return d;
  endfunction

endpackage

`default_nettype wire

/* hdl/clars_in_if.sv */
// Input channel of the line sender: op, data byte and last-byte flag.
// Depends on clars_pkg for field widths.
`default_nettype none

interface clars_in_if;
  logic                         valid;
  logic                         ready;
  logic [clars_pkg::OP_W-1:0]   op;
  logic [clars_pkg::BYTE_W-1:0] data_byte;
  logic                         last_byte;

  modport source (output valid, output op, output data_byte, output last_byte,
                  input ready);
  modport sink   (input valid, input op, input data_byte, input last_byte,
                  output ready);
endinterface

`default_nettype wire

/* hdl/clars_out_if.sv */
// Result channel of the line sender: transmit byte and completion status.
// Depends on clars_pkg for field widths.
`default_nettype none

interface clars_out_if;
  logic                         valid;
  logic                         ready;
  logic                         tx_valid;
  logic [clars_pkg::BYTE_W-1:0] tx_byte;
  logic                         done_res;
  logic                         acked;

  modport source (output valid, output tx_valid, output tx_byte, output done_res,
                  output acked, input ready);
  modport sink   (input valid, input tx_valid, input tx_byte, input done_res,
                  input acked, output ready);
endinterface

`default_nettype wire

/* hdl/clars_msg_ram.sv */
// Message byte store: one write port, one read port, registered read data.
// Standalone; sized by its parameters.
`default_nettype none

module clars_msg_ram #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int DW    = 8
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (re) rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* hdl/checksummed_line_ack_retry_sender.sv */
// Stop-and-wait line sender: loads a line, sends it with an XOR checksum trailer,
// checks a four-byte decimal acknowledgement and resends on failure or timeout.
// Depends on clars_pkg, clars_in_if, clars_out_if and clars_msg_ram.
//
// One item is accepted per cycle unless the result stage is full and stalled. Each
// item updates the control state in the cycle it is accepted and any result item
// enters a stage register at that edge, together with the registered read of the
// message store for message bytes; from there it moves to the output register when
// that is free or being taken. The stage register and the output register hold up
// to two pending results, so input keeps flowing while one result waits to be
// taken. Up to MSG_DEPTH-1 bytes of a line are kept; the store needs no clearing
// after reset.
`default_nettype none

module checksummed_line_ack_retry_sender #(
  parameter int MSG_DEPTH = 64
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  clars_in_if.sink                               in_ch,
  clars_out_if.source                            out_ch,
  input  wire logic                              cfg_we,
  input  wire logic [clars_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [clars_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int AW = $clog2(MSG_DEPTH);
  localparam logic [AW-1:0] LEN_MAX = AW'(MSG_DEPTH - 1);

  logic [clars_pkg::RETRY_W-1:0]  retry_limit_r;
  logic [clars_pkg::TICK_W-1:0]   ack_timeout_r;

  logic [AW-1:0]                  msg_len_r, msg_len_nxt;
  logic [clars_pkg::BYTE_W-1:0]   checksum_r, checksum_nxt;
  logic [clars_pkg::PHASE_W-1:0]  phase_r, phase_nxt;
  logic [AW-1:0]                  send_pos_r, send_pos_nxt;
  logic [clars_pkg::TRAIL_W-1:0]  trail_pos_r, trail_pos_nxt;
  logic [clars_pkg::RETRY_W-1:0]  attempt_r, attempt_nxt;
  logic [clars_pkg::TICK_W-1:0]   wait_ticks_r, wait_ticks_nxt;
  logic [clars_pkg::ACKCNT_W-1:0] ack_cnt_r, ack_cnt_nxt;
  logic [clars_pkg::BYTE_W-1:0]   ack_val_r, ack_val_nxt;
  logic                           ack_ok_r, ack_ok_nxt;

  logic                           s1_valid_r, s1_valid_nxt;
  logic                           s1_from_mem_r;
  clars_pkg::out_item_t           s1_item_r;
  clars_pkg::out_item_t           s1_fwd;
  logic                           out_valid_r, out_valid_nxt;
  clars_pkg::out_item_t           out_item_r;

  logic                           acc, s1_move;
  logic                           res_valid, res_from_mem;
  clars_pkg::out_item_t           res_item;
  logic                           ram_we, ram_re;
  logic [clars_pkg::BYTE_W-1:0]   ram_q;

  clars_pkg::digits_t             dig;
  logic [1:0]                     num_digits;
  logic [clars_pkg::TRAIL_W-1:0]  trail_end, digit_shift;
  logic [3:0]                     digit_val;
  logic [clars_pkg::BYTE_W-1:0]   trail_char;

  logic [clars_pkg::RETRY_W-1:0]  attempt_inc;
  logic                           give_up;
  logic [clars_pkg::BYTE_W-1:0]   rx_digit;
  logic [clars_pkg::BYTE_W-1:0]   tick_val;

  assign s1_move     = !out_valid_r || out_ch.ready;
  assign in_ch.ready = !s1_valid_r || s1_move;
  assign acc         = in_ch.valid && in_ch.ready;

  // Trailer character for the current trailer position.
  always_comb begin
    dig         = clars_pkg::to_digits(checksum_r);
    num_digits  = (dig.hund != 2'd0) ? 2'd3 : ((dig.tens != 4'd0) ? 2'd2 : 2'd1);
    trail_end   = 3'd2 + {1'b0, num_digits};
    digit_shift = {1'b0, num_digits} - 3'd1 - (trail_pos_r - 3'd2);
    case (digit_shift)
      3'd2:    digit_val = {2'b00, dig.hund};
      3'd1:    digit_val = dig.tens;
      default: digit_val = dig.ones;
    endcase
    if (trail_pos_r == 3'd0) begin
      trail_char = clars_pkg::CH_SPACE;
    end else if (trail_pos_r == 3'd1) begin
      trail_char = clars_pkg::CH_STAR;
    end else if (trail_pos_r < trail_end) begin
      trail_char = clars_pkg::CH_ZERO + {4'd0, digit_val};
    end else if (trail_pos_r == trail_end) begin
      trail_char = clars_pkg::CH_CR;
    end else begin
      trail_char = clars_pkg::CH_LF;
    end
  end

  assign attempt_inc = attempt_r + 8'd1;
  assign give_up     = (retry_limit_r != '0) && (attempt_inc >= retry_limit_r);
  assign rx_digit    = in_ch.data_byte - clars_pkg::CH_ZERO;
  assign tick_val    = '0;

  always_comb begin
    msg_len_nxt    = msg_len_r;
    checksum_nxt   = checksum_r;
    phase_nxt      = phase_r;
    send_pos_nxt   = send_pos_r;
    trail_pos_nxt  = trail_pos_r;
    attempt_nxt    = attempt_r;
    wait_ticks_nxt = wait_ticks_r;
    ack_cnt_nxt    = ack_cnt_r;
    ack_val_nxt    = ack_val_r;
    ack_ok_nxt     = ack_ok_r;
    res_valid      = 1'b0;
    res_from_mem   = 1'b0;
    res_item       = '0;
    ram_we         = 1'b0;
    ram_re         = 1'b0;

    if (acc) begin
      case (in_ch.op)
        clars_pkg::OP_LOAD: begin
          if (phase_r != clars_pkg::PH_SEND && phase_r != clars_pkg::PH_WAIT) begin
            if (msg_len_r < LEN_MAX) begin
              ram_we       = 1'b1;
              msg_len_nxt  = msg_len_r + AW'(1);
              checksum_nxt = checksum_r ^ in_ch.data_byte;
            end
            if (in_ch.last_byte) begin
              attempt_nxt   = '0;
              phase_nxt     = clars_pkg::PH_SEND;
              send_pos_nxt  = '0;
              trail_pos_nxt = '0;
            end
          end
        end
        clars_pkg::OP_RX: begin
          if (phase_r == clars_pkg::PH_WAIT) begin
            if (ack_cnt_r == '0) begin
              ack_ok_nxt = (in_ch.data_byte == clars_pkg::CH_A);
            end else if (in_ch.data_byte >= clars_pkg::CH_ZERO &&
                         in_ch.data_byte <= clars_pkg::CH_NINE) begin
              ack_val_nxt = {ack_val_r[4:0], 3'b000} + {ack_val_r[6:0], 1'b0} + rx_digit;
            end else begin
              ack_ok_nxt = 1'b0;
            end
            ack_cnt_nxt = ack_cnt_r + 3'd1;
            if (ack_cnt_nxt == clars_pkg::ACK_LEN) begin
              if (ack_ok_nxt && ack_val_nxt == checksum_r) begin
                phase_nxt         = clars_pkg::PH_IDLE;
                msg_len_nxt       = '0;
                checksum_nxt      = '0;
                send_pos_nxt      = '0;
                trail_pos_nxt     = '0;
                res_valid         = 1'b1;
                res_item.done_res = 1'b1;
                res_item.acked    = 1'b1;
              end else begin
                attempt_nxt = attempt_inc;
                if (give_up) begin
                  phase_nxt         = clars_pkg::PH_IDLE;
                  msg_len_nxt       = '0;
                  checksum_nxt      = '0;
                  res_valid         = 1'b1;
                  res_item.done_res = 1'b1;
                end else begin
                  phase_nxt = clars_pkg::PH_SEND;
                end
                send_pos_nxt  = '0;
                trail_pos_nxt = '0;
              end
            end
          end
        end
        clars_pkg::OP_TICK: begin
          if (phase_r == clars_pkg::PH_WAIT) begin
            if (wait_ticks_r < clars_pkg::TICK_MAX) wait_ticks_nxt = wait_ticks_r + 16'd1;
            if (wait_ticks_nxt >= ack_timeout_r) begin
              attempt_nxt = attempt_inc;
              if (give_up) begin
                phase_nxt         = clars_pkg::PH_IDLE;
                msg_len_nxt       = '0;
                checksum_nxt      = '0;
                res_valid         = 1'b1;
                res_item.done_res = 1'b1;
              end else begin
                phase_nxt = clars_pkg::PH_SEND;
              end
              send_pos_nxt  = '0;
              trail_pos_nxt = '0;
            end
          end
        end
        default: begin
          if (phase_r == clars_pkg::PH_SEND) begin
            res_valid         = 1'b1;
            res_item.tx_valid = 1'b1;
            if (send_pos_r < msg_len_r) begin
              ram_re       = 1'b1;
              res_from_mem = 1'b1;
              send_pos_nxt = send_pos_r + AW'(1);
            end else begin
              res_item.tx_byte = trail_char;
              if (trail_char == clars_pkg::CH_LF) begin
                phase_nxt      = clars_pkg::PH_WAIT;
                trail_pos_nxt  = '0;
                wait_ticks_nxt = tick_val;
                ack_cnt_nxt    = '0;
                ack_val_nxt    = '0;
                ack_ok_nxt     = 1'b1;
              end else begin
                trail_pos_nxt = trail_pos_r + 3'd1;
              end
            end
          end
        end
      endcase
    end
  end

  clars_msg_ram #(
    .DEPTH (MSG_DEPTH),
    .AW    (AW),
    .DW    (clars_pkg::BYTE_W)
  ) u_msg_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (msg_len_r),
    .wdata (in_ch.data_byte),
    .re    (ram_re),
    .raddr (send_pos_r),
    .rdata (ram_q)
  );

  always_comb begin
    if (acc && res_valid) s1_valid_nxt = 1'b1;
    else if (s1_move)     s1_valid_nxt = 1'b0;
    else                  s1_valid_nxt = s1_valid_r;
    out_valid_nxt = s1_move ? s1_valid_r : out_valid_r;
  end

  always_comb begin
    s1_fwd = s1_item_r;
    if (s1_from_mem_r) s1_fwd.tx_byte = ram_q;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      retry_limit_r <= clars_pkg::RETRY_LIMIT_RST;
      ack_timeout_r <= clars_pkg::ACK_TIMEOUT_RST;
      msg_len_r     <= '0;
      checksum_r    <= '0;
      phase_r       <= clars_pkg::PH_IDLE;
      send_pos_r    <= '0;
      trail_pos_r   <= '0;
      attempt_r     <= '0;
      wait_ticks_r  <= '0;
      ack_cnt_r     <= '0;
      ack_val_r     <= '0;
      ack_ok_r      <= 1'b1;
      s1_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          clars_pkg::CFG_RETRY_LIMIT: retry_limit_r <= cfg_data[clars_pkg::RETRY_W-1:0];
          clars_pkg::CFG_ACK_TIMEOUT: ack_timeout_r <= cfg_data[clars_pkg::TICK_W-1:0];
          default: ;
        endcase
      end
      msg_len_r    <= msg_len_nxt;
      checksum_r   <= checksum_nxt;
      phase_r      <= phase_nxt;
      send_pos_r   <= send_pos_nxt;
      trail_pos_r  <= trail_pos_nxt;
      attempt_r    <= attempt_nxt;
      wait_ticks_r <= wait_ticks_nxt;
      ack_cnt_r    <= ack_cnt_nxt;
      ack_val_r    <= ack_val_nxt;
      ack_ok_r     <= ack_ok_nxt;
      s1_valid_r   <= s1_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && res_valid) begin
      s1_item_r     <= res_item;
      s1_from_mem_r <= res_from_mem;
    end
    if (s1_move && s1_valid_r) begin
      out_item_r <= s1_fwd;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.tx_valid = out_item_r.tx_valid;
  assign out_ch.tx_byte  = out_item_r.tx_byte;
  assign out_ch.done_res = out_item_r.done_res;
  assign out_ch.acked    = out_item_r.acked;

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    msg_len_r <= LEN_MAX)
    else $error("message length beyond store");

  a_send_pos: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == clars_pkg::PH_SEND |-> send_pos_r <= msg_len_r)
    else $error("send position past line end");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    acc |-> !(s1_valid_r && !s1_move))
    else $error("item accepted with full result stage");

  a_done_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && res_valid && res_item.done_res) |=>
      (phase_r == clars_pkg::PH_IDLE && msg_len_r == '0 && checksum_r == '0))
    else $error("line not cleared after finish");

  a_ack_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == clars_pkg::PH_WAIT |-> ack_cnt_r < clars_pkg::ACK_LEN)
    else $error("ack byte count overflow while waiting");

endmodule

`default_nettype wire
